// File: hdl/mcbfp_pkg.sv
`timescale 1ns / 1ps

package mcbfp_pkg;

	// Marker bytes of the three frame kinds
	localparam logic [7:0] BYTE_ROOM    = 8'h4E;  // 'N'
	localparam logic [7:0] BYTE_CMD     = 8'h43;  // 'C'
	localparam logic [7:0] BYTE_CMD_END = 8'h4D;  // 'M'
	localparam logic [7:0] BYTE_HEADER  = 8'hAA;
	localparam logic [7:0] BYTE_TRAILER = 8'h55;
	localparam logic [7:0] BYTE_DIGIT_1 = 8'h31;  // '1'
	localparam logic [7:0] BYTE_DIGIT_8 = 8'h38;  // '8'

	// Command codes
	localparam logic [2:0] CMD_NONE = 3'd0;
	localparam logic [2:0] CMD_A    = 3'd1;
	localparam logic [2:0] CMD_D    = 3'd2;
	localparam logic [2:0] CMD_S    = 3'd3;
	localparam logic [2:0] CMD_W    = 3'd4;
	localparam logic [2:0] CMD_G    = 3'd5;
	localparam logic [2:0] CMD_P    = 3'd6;

	// Held values after reset, in tenths
	localparam logic signed [15:0] VALUE_RESET = 16'sd2000;

	localparam int OUT_BITS  = 59;
	localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

	typedef enum logic [1:0] {
		CPH_IDLE   = 2'd0,
		CPH_LETTER = 2'd1,
		CPH_END    = 2'd2
	} cmd_phase_t;

	typedef enum logic [2:0] {
		BPH_HUNT    = 3'd0,
		BPH_TGT_LO  = 3'd1,
		BPH_TGT_HI  = 3'd2,
		BPH_CUR_LO  = 3'd3,
		BPH_CUR_HI  = 3'd4,
		BPH_TRAILER = 3'd5
	} bin_phase_t;

	// One result item
	typedef struct packed {
		logic signed [16:0] offset_tenths;
		logic signed [15:0] current_tenths;
		logic signed [15:0] target_tenths;
		logic               frame_update;
		logic [2:0]         command_code;
		logic               command_update;
		logic [3:0]         room_number;
		logic               room_update;
	} result_t;

	// Map a command letter to its code, CMD_NONE for anything else
	function automatic logic [2:0] letter_code(input logic [7:0] b);
		logic [2:0] code;
		unique case (b)
			8'h41:   code = CMD_A;
			8'h44:   code = CMD_D;
			8'h53:   code = CMD_S;
			8'h57:   code = CMD_W;
			8'h47:   code = CMD_G;
			8'h50:   code = CMD_P;
			default: code = CMD_NONE;
		endcase
		return code;
	endfunction

endpackage

// File: hdl/multi_channel_byte_frame_parser_top.sv
`timescale 1ns / 1ps

// Channel  Dir  tdata bits                                          Handshake
// s_*      in   [7:0] rx_byte                                       tvalid/tready
// m_*      out  [0] room_update [4:1] room_number [5] command_update tvalid/tready
//               [8:6] command_code [9] frame_update [25:10] target_tenths
//               [41:26] current_tenths [58:42] offset_tenths [63:59] zero
//
// One byte per cycle sustained while the result side is ready; a byte passes the input
// register, then the parser state update into the result register.
// arst_n clears the parser state, sets target and current to 2000 tenths.
// When the result waits, the input register still takes one more byte; then tready drops.

module multi_channel_byte_frame_parser_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [7:0]                            s_tdata,   // rx_byte
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// room_update, room_number, command_update, command_code, frame_update,
	// target_tenths, current_tenths, offset_tenths, zero fill
	output logic [mcbfp_pkg::OUT_BYTES*8-1:0]     m_tdata
);

	// Input register
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       adv;

	// Parser state
	logic                  room_pend_q;
	mcbfp_pkg::cmd_phase_t cph_q;
	logic [2:0]            cand_q;
	mcbfp_pkg::bin_phase_t bph_q;
	logic [7:0]            frame_q [4];
	logic [3:0]            room_q;
	logic [2:0]            cmd_q;
	logic signed [15:0]    tgt_q;
	logic signed [15:0]    cur_q;
	logic signed [16:0]    off_q;

	// Next state
	logic                  room_pend_d;
	mcbfp_pkg::cmd_phase_t cph_d;
	logic [2:0]            cand_d;
	mcbfp_pkg::bin_phase_t bph_d;
	logic [3:0]            room_d;
	logic [2:0]            cmd_d;
	logic signed [15:0]    tgt_d;
	logic signed [15:0]    cur_d;
	logic signed [16:0]    off_d;
	logic                  frame_wr;
	logic [1:0]            frame_idx;
	logic                  room_upd, cmd_upd, frame_upd;
	logic                  pass;
	logic [2:0]            code;

	// Output register
	logic                  out_vld_q;
	mcbfp_pkg::result_t    out_q;

	assign adv      = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(mcbfp_pkg::OUT_BYTES*8-mcbfp_pkg::OUT_BITS){1'b0}}, out_q};

	// Capture the incoming byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// Room, command and binary matchers in priority order
	always_comb begin
		room_pend_d = room_pend_q;
		cph_d       = cph_q;
		cand_d      = cand_q;
		bph_d       = bph_q;
		room_d      = room_q;
		cmd_d       = cmd_q;
		tgt_d       = tgt_q;
		cur_d       = cur_q;
		off_d       = off_q;
		room_upd    = 1'b0;
		cmd_upd     = 1'b0;
		frame_upd   = 1'b0;
		frame_wr    = 1'b0;
		frame_idx   = 2'd0;
		pass        = 1'b0;
		code        = mcbfp_pkg::letter_code(byte_s1);

		priority if (room_pend_q) begin
			if (byte_s1 >= mcbfp_pkg::BYTE_DIGIT_1 && byte_s1 <= mcbfp_pkg::BYTE_DIGIT_8) begin
				room_d   = byte_s1[3:0];
				room_upd = 1'b1;
			end
			room_pend_d = 1'b0;
		end else if (byte_s1 == mcbfp_pkg::BYTE_ROOM) begin
			room_pend_d = 1'b1;
			bph_d       = mcbfp_pkg::BPH_HUNT;
		end else if (cph_q == mcbfp_pkg::CPH_LETTER) begin
			if (code != mcbfp_pkg::CMD_NONE) begin
				cand_d = code;
				cph_d  = mcbfp_pkg::CPH_END;
			end else if (byte_s1 == mcbfp_pkg::BYTE_CMD) begin
				cph_d = mcbfp_pkg::CPH_LETTER;
			end else begin
				cph_d = mcbfp_pkg::CPH_IDLE;
				pass  = 1'b1;
			end
		end else if (cph_q == mcbfp_pkg::CPH_END) begin
			if (byte_s1 == mcbfp_pkg::BYTE_CMD_END) begin
				cmd_d       = cand_q;
				cmd_upd     = 1'b1;
				bph_d       = mcbfp_pkg::BPH_HUNT;
				room_pend_d = 1'b0;
				cph_d       = mcbfp_pkg::CPH_IDLE;
			end else if (byte_s1 == mcbfp_pkg::BYTE_CMD) begin
				cph_d = mcbfp_pkg::CPH_LETTER;
			end else begin
				cph_d = mcbfp_pkg::CPH_IDLE;
				pass  = 1'b1;
			end
		end else if (byte_s1 == mcbfp_pkg::BYTE_CMD) begin
			cph_d = mcbfp_pkg::CPH_LETTER;
			bph_d = mcbfp_pkg::BPH_HUNT;
		end else begin
			// Unused command phase falls back to idle here
			cph_d = mcbfp_pkg::CPH_IDLE;
			pass  = 1'b1;
		end

		// Binary frame collector
		if (pass) begin
			unique case (bph_q)
				mcbfp_pkg::BPH_HUNT: begin
					if (byte_s1 == mcbfp_pkg::BYTE_HEADER) begin
						bph_d = mcbfp_pkg::BPH_TGT_LO;
					end
				end
				mcbfp_pkg::BPH_TGT_LO, mcbfp_pkg::BPH_TGT_HI,
				mcbfp_pkg::BPH_CUR_LO, mcbfp_pkg::BPH_CUR_HI: begin
					frame_wr  = 1'b1;
					frame_idx = 2'(bph_q - 3'd1);
					bph_d     = mcbfp_pkg::bin_phase_t'(bph_q + 3'd1);
				end
				mcbfp_pkg::BPH_TRAILER: begin
					if (byte_s1 == mcbfp_pkg::BYTE_TRAILER) begin
						tgt_d     = {frame_q[1], frame_q[0]};
						cur_d     = {frame_q[3], frame_q[2]};
						off_d     = 17'(tgt_d) - 17'(cur_d);
						frame_upd = 1'b1;
					end
					bph_d = mcbfp_pkg::BPH_HUNT;
				end
				default: begin
					bph_d = mcbfp_pkg::BPH_HUNT;
				end
			endcase
		end
	end

	// Advance parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_pend_q <= 1'b0;
			cph_q       <= mcbfp_pkg::CPH_IDLE;
			cand_q      <= mcbfp_pkg::CMD_NONE;
			bph_q       <= mcbfp_pkg::BPH_HUNT;
			room_q      <= 4'd0;
			cmd_q       <= mcbfp_pkg::CMD_NONE;
			tgt_q       <= mcbfp_pkg::VALUE_RESET;
			cur_q       <= mcbfp_pkg::VALUE_RESET;
			off_q       <= 17'sd0;
		end else if (adv) begin
			room_pend_q <= room_pend_d;
			cph_q       <= cph_d;
			cand_q      <= cand_d;
			bph_q       <= bph_d;
			room_q      <= room_d;
			cmd_q       <= cmd_d;
			tgt_q       <= tgt_d;
			cur_q       <= cur_d;
			off_q       <= off_d;
		end
	end

	// Store frame payload bytes
	always_ff @(posedge clk) begin
		if (adv && frame_wr) begin
			frame_q[frame_idx] <= byte_s1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.room_update    <= room_upd;
			out_q.room_number    <= room_d;
			out_q.command_update <= cmd_upd;
			out_q.command_code   <= cmd_d;
			out_q.frame_update   <= frame_upd;
			out_q.target_tenths  <= tgt_d;
			out_q.current_tenths <= cur_d;
			out_q.offset_tenths  <= off_d;
		end
	end

endmodule

// File: bench/parser_result_checker.sv
`timescale 1ns / 1ps

module parser_result_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // rx_byte
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	// room_update, room_number, command_update, command_code, frame_update,
	// target_tenths, current_tenths, offset_tenths, zero fill
	input  logic [mcbfp_pkg::OUT_BYTES*8-1:0] m_tdata,
	output int                                outstanding,
	output int                                mismatches
);

	import mcbfp_pkg::*;

	// Predicted parser state
	logic              room_armed;
	cmd_phase_t        cmd_ph;
	logic [2:0]        cmd_cand;
	bin_phase_t        bin_ph;
	logic [7:0]        frame_buf [0:3];
	logic [3:0]        room_q;
	logic [2:0]        cmd_q;
	logic signed [15:0] tgt_q;
	logic signed [15:0] cur_q;
	logic signed [16:0] ofs_q;

	result_t     parser_reports_q [$];
	result_t     got;
	result_t     want;
	int unsigned bad_count;
	int unsigned results_seen;
	logic        field_bad;

	// Advance the predicted parser by one byte and return the report it gives
	function automatic result_t parse_byte(input logic [7:0] b);
		result_t    r;
		logic       to_binary;
		logic [2:0] code;
		r = '0;
		to_binary = 1'b0;
		case (b)
			"A":     code = CMD_A;
			"D":     code = CMD_D;
			"S":     code = CMD_S;
			"W":     code = CMD_W;
			"G":     code = CMD_G;
			"P":     code = CMD_P;
			default: code = CMD_NONE;
		endcase

		// Room matcher has priority, then the command matcher
		if (room_armed) begin
			if (b >= BYTE_DIGIT_1 && b <= BYTE_DIGIT_8) begin
				room_q = 4'(b - BYTE_DIGIT_1) + 4'd1;
				r.room_update = 1'b1;
			end
			room_armed = 1'b0;
		end else if (b == BYTE_ROOM) begin
			room_armed = 1'b1;
			bin_ph = BPH_HUNT;
		end else if (cmd_ph == CPH_LETTER) begin
			if (code != CMD_NONE) begin
				cmd_cand = code;
				cmd_ph = CPH_END;
			end else if (b == BYTE_CMD) begin
				cmd_ph = CPH_LETTER;
			end else begin
				cmd_ph = CPH_IDLE;
				to_binary = 1'b1;
			end
		end else if (cmd_ph == CPH_END) begin
			if (b == BYTE_CMD_END) begin
				cmd_q = cmd_cand;
				r.command_update = 1'b1;
				bin_ph = BPH_HUNT;
				room_armed = 1'b0;
				cmd_ph = CPH_IDLE;
			end else if (b == BYTE_CMD) begin
				cmd_ph = CPH_LETTER;
			end else begin
				cmd_ph = CPH_IDLE;
				to_binary = 1'b1;
			end
		end else if (b == BYTE_CMD) begin
			cmd_ph = CPH_LETTER;
			bin_ph = BPH_HUNT;
		end else begin
			to_binary = 1'b1;
		end

		// Binary frame collector
		if (to_binary) begin
			case (bin_ph)
				BPH_HUNT: begin
					if (b == BYTE_HEADER)
						bin_ph = BPH_TGT_LO;
				end
				BPH_TRAILER: begin
					if (b == BYTE_TRAILER) begin
						tgt_q = {frame_buf[1], frame_buf[0]};
						cur_q = {frame_buf[3], frame_buf[2]};
						ofs_q = {tgt_q[15], tgt_q} - {cur_q[15], cur_q};
						r.frame_update = 1'b1;
					end
					bin_ph = BPH_HUNT;
				end
				default: begin
					frame_buf[int'(bin_ph) - int'(BPH_TGT_LO)] = b;
					bin_ph = bin_phase_t'(bin_ph + 3'd1);
				end
			endcase
		end

		r.room_number = room_q;
		r.command_code = cmd_q;
		r.target_tenths = tgt_q;
		r.current_tenths = cur_q;
		r.offset_tenths = ofs_q;
		return r;
	endfunction

	function automatic string show(input result_t r);
		return $sformatf("room %0d/%0d cmd %0d/%0d frame %0d tgt %0d cur %0d ofs %0d",
			r.room_update, r.room_number, r.command_update, r.command_code,
			r.frame_update, r.target_tenths, r.current_tenths, r.offset_tenths);
	endfunction

	// Track both channels: check each report, then predict the new request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_armed = 1'b0;
			cmd_ph = CPH_IDLE;
			cmd_cand = CMD_NONE;
			bin_ph = BPH_HUNT;
			for (int i = 0; i < 4; i++)
				frame_buf[i] = '0;
			room_q = '0;
			cmd_q = CMD_NONE;
			tgt_q = VALUE_RESET;
			cur_q = VALUE_RESET;
			ofs_q = '0;
			parser_reports_q.delete();
			bad_count = 0;
			results_seen = 0;
			outstanding <= 0;
			mismatches <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[OUT_BITS-1:0]);
				if (parser_reports_q.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("unexpected report %0d: %s", results_seen, show(got));
				end else begin
					want = parser_reports_q.pop_front();
					field_bad = (got.room_update !== want.room_update)
						|| (got.room_number !== want.room_number)
						|| (got.command_update !== want.command_update)
						|| (got.command_code !== want.command_code)
						|| (got.frame_update !== want.frame_update)
						|| (got.target_tenths !== want.target_tenths)
						|| (got.current_tenths !== want.current_tenths)
						|| (got.offset_tenths !== want.offset_tenths)
						|| (m_tdata[OUT_BYTES*8-1:OUT_BITS] !== '0);
					if (field_bad) begin
						bad_count++;
						if (bad_count <= 10) begin
							$display("report %0d mismatch", results_seen);
							$display("  expected %s", show(want));
							$display("  actual   %s fill %h", show(got),
								m_tdata[OUT_BYTES*8-1:OUT_BITS]);
						end
					end
				end
				results_seen++;
			end
			if (s_tvalid && s_tready)
				parser_reports_q.push_back(parse_byte(s_tdata));
			outstanding <= parser_reports_q.size();
			mismatches <= bad_count;
		end
	end

endmodule

// File: bench/multi_channel_byte_frame_parser_top_tb.sv
`timescale 1ns / 1ps

module multi_channel_byte_frame_parser_top_tb;

	import mcbfp_pkg::*;

	localparam int ITEMS       = 1650;
	localparam int CALM_FROM   = 1450;
	localparam int STALL_LIMIT = 2000;

	// Directed opening: rooms, commands with restart and room inside, broken
	// command falling through to a binary frame at the value extremes
	localparam logic [7:0] OPENING [23] = '{
		BYTE_ROOM, "1",
		BYTE_ROOM, "9",
		BYTE_CMD, "A", BYTE_CMD_END,
		BYTE_CMD, BYTE_CMD, "D", BYTE_CMD_END,
		BYTE_CMD, "S", BYTE_ROOM, BYTE_DIGIT_8, BYTE_CMD_END,
		BYTE_CMD, BYTE_HEADER, 8'h00, 8'h80, 8'hFF, 8'h7F, BYTE_TRAILER
	};
	localparam logic [7:0] LETTERS [6] = '{"A", "D", "S", "W", "G", "P"};

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [7:0]             s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_BYTES*8-1:0] m_tdata;

	int   outstanding;
	int   mismatches;
	int   sent = 0;
	int   idle_cycles = 0;
	logic calm = 1'b0;

	multi_channel_byte_frame_parser_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	parser_result_checker result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Offer one byte, maybe after a gap, and hold it until taken
	task automatic send_byte(input logic [7:0] b);
		if (!calm && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
		if (sent >= CALM_FROM)
			calm = 1'b1;
	endtask

	// Mostly random words, with the signed extremes mixed in
	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'hFFFF;
			3:       return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Stimulus: reset, directed opening, then random frames and noise
	initial begin
		logic [7:0]  frame_q [$];
		logic [15:0] w;
		int          pick;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (OPENING[i])
			send_byte(OPENING[i]);

		while (sent < ITEMS) begin
			frame_q.delete();
			pick = $urandom_range(0, 99);
			if (pick < 20) begin
				frame_q.push_back(BYTE_ROOM);
				if ($urandom_range(0, 6) != 0)
					frame_q.push_back(BYTE_DIGIT_1 + 8'($urandom_range(0, 7)));
				else
					frame_q.push_back(8'($urandom_range(0, 255)));
			end else if (pick < 45) begin
				frame_q.push_back(BYTE_CMD);
				if ($urandom_range(0, 9) == 0)
					frame_q.push_back(BYTE_CMD);
				if ($urandom_range(0, 9) != 0)
					frame_q.push_back(LETTERS[$urandom_range(0, 5)]);
				else
					frame_q.push_back(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 9) != 0)
					frame_q.push_back(BYTE_CMD_END);
				else
					frame_q.push_back(8'($urandom_range(0, 255)));
			end else if (pick < 85) begin
				frame_q.push_back(BYTE_HEADER);
				w = pick_word();
				frame_q.push_back(w[7:0]);
				frame_q.push_back(w[15:8]);
				w = pick_word();
				frame_q.push_back(w[7:0]);
				frame_q.push_back(w[15:8]);
				if ($urandom_range(0, 6) != 0)
					frame_q.push_back(BYTE_TRAILER);
				else
					frame_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 4))
					frame_q.push_back(8'($urandom_range(0, 255)));
			end
			foreach (frame_q[i])
				send_byte(frame_q[i]);
		end

		// Drain and settle
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Result side: ready in runs, stalled in random bursts until the calm part
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if (!calm && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
		end
	end

	// Watchdog: stop when no request moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
